// File: hdl/kmc_pkg.sv
// Shared constants, types and helpers for the k-means clustering unit.
package kmc_pkg;

  localparam int unsigned MAX_VECTORS_DEF  = 1024;
  localparam int unsigned MAX_CLUSTERS_DEF = 8;
  localparam int unsigned MAX_DIM_DEF      = 8;

  localparam logic [3:0] RESET_NUM_CLUSTERS  = 4'd2;
  localparam logic [3:0] RESET_VECTOR_LENGTH = 4'd2;
  localparam logic [9:0] RESET_MAX_ITER      = 10'd200;

  localparam logic [1:0] REG_NUM_CLUSTERS  = 2'd0;
  localparam logic [1:0] REG_VECTOR_LENGTH = 2'd1;
  localparam logic [1:0] REG_MAX_ITER      = 2'd2;

  // One component transaction handed from the loader to the engine.
  typedef struct packed {
    logic [31:0] comp;
    logic        last;
  } kmc_item_t;

  // Clamp a 4-bit register into 1..hi.
  function automatic logic [3:0] clamp_cfg(input logic [3:0] v, input logic [3:0] hi);
    logic [3:0] r;
    begin
      r = v;
      if (v == 4'd0) r = 4'd1;
      else if (v > hi) r = hi;
      return r;
    end
  endfunction

endpackage

// File: hdl/kmeans_lloyd_clustering_unit.sv
// Top level of the k-means clustering unit: configuration, queue and engine.
// Components stream in one per cycle into a two-entry queue and are stored in an
// on-chip vector memory at one component per cycle. After the component marked
// last, the input stalls while the engine seeds centroids (when there are more
// vectors than clusters) and runs Lloyd rounds: each vector is fetched, its
// distances are squared on one 32-bit multiplier and it is added into its
// cluster sums, and each centroid update runs a serial divide per component.
// Cluster sums start from zero each round through the cluster sizes, without a
// clearing pass. The k*d results then leave one at a time; a new set is taken
// after.
module kmeans_lloyd_clustering_unit #(
  parameter int unsigned MAX_VECTORS  = kmc_pkg::MAX_VECTORS_DEF,
  parameter int unsigned MAX_CLUSTERS = kmc_pkg::MAX_CLUSTERS_DEF,
  parameter int unsigned MAX_DIM      = kmc_pkg::MAX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // component
  input  logic        in_tlast,   // last_of_set
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // centroid_component, cluster_index, component_index,
                                  // rounds_run
  output logic        out_tlast,  // last_result
  output logic        out_tuser   // too_few_vectors
);

  logic [3:0] num_clusters_r, vector_length_r;
  logic [9:0] max_iter_r;
  kmc_pkg::kmc_item_t q_in, q_out;
  logic q_valid, q_ready;
  logic [31:0] r_comp;
  logic [2:0]  r_cl, r_ix;
  logic [9:0]  r_rounds;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_clusters_r  <= kmc_pkg::RESET_NUM_CLUSTERS;
      vector_length_r <= kmc_pkg::RESET_VECTOR_LENGTH;
      max_iter_r      <= kmc_pkg::RESET_MAX_ITER;
    end else if (cfg_valid) begin
      if (cfg_index == kmc_pkg::REG_NUM_CLUSTERS)  num_clusters_r  <= cfg_data[3:0];
      if (cfg_index == kmc_pkg::REG_VECTOR_LENGTH) vector_length_r <= cfg_data[3:0];
      if (cfg_index == kmc_pkg::REG_MAX_ITER)      max_iter_r      <= cfg_data;
    end
  end

  assign q_in.comp = in_tdata;
  assign q_in.last = in_tlast;

  kmc_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_tvalid), .wr_ready(in_tready), .wr_data(q_in),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_out)
  );

  kmc_engine #(
    .MAX_VECTORS(MAX_VECTORS), .MAX_CLUSTERS(MAX_CLUSTERS), .MAX_DIM(MAX_DIM)
  ) u_engine (
    .clk(clk), .rst_n(rst_n),
    .num_clusters(num_clusters_r), .vector_length(vector_length_r),
    .max_iterations(max_iter_r),
    .item_valid(q_valid), .item_ready(q_ready), .item(q_out),
    .res_valid(out_tvalid), .res_ready(out_tready),
    .res_comp(r_comp), .res_cluster(r_cl), .res_index(r_ix),
    .res_last(out_tlast), .res_few(out_tuser), .res_rounds(r_rounds)
  );

  assign out_tdata = {r_rounds, r_ix, r_cl, r_comp};

endmodule

// File: hdl/kmc_queue.sv
// Two-entry queue between the input front end and the clustering engine.
module kmc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  kmc_pkg::kmc_item_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output kmc_pkg::kmc_item_t rd_data
);

  kmc_pkg::kmc_item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Pointer and occupancy update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) wp_r <= ~wp_r;
      if (do_rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  // Payload storage.
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

endmodule

// File: hdl/kmc_engine.sv
// Back end: stores vectors, runs Lloyd rounds and emits the final centroids.
module kmc_engine #(
  parameter int unsigned MAX_VECTORS  = kmc_pkg::MAX_VECTORS_DEF,
  parameter int unsigned MAX_CLUSTERS = kmc_pkg::MAX_CLUSTERS_DEF,
  parameter int unsigned MAX_DIM      = kmc_pkg::MAX_DIM_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [3:0]         num_clusters,
  input  logic [3:0]         vector_length,
  input  logic [9:0]         max_iterations,
  input  logic               item_valid,
  output logic               item_ready,
  input  kmc_pkg::kmc_item_t item,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [31:0]        res_comp,
  output logic [2:0]         res_cluster,
  output logic [2:0]         res_index,
  output logic               res_last,
  output logic               res_few,
  output logic [9:0]         res_rounds
);

  localparam int VW  = $clog2(MAX_VECTORS + 1);   // vector count width
  localparam int VIW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
  localparam int SW  = VIW + 32;                  // exact sum width
  localparam int AW  = VIW + 3;                   // vector store address

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_SEED  = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_DIST  = 4'd3;
  localparam logic [3:0] S_ACC   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_DIVR  = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;
  localparam logic [3:0] S_PAD   = 4'd8;
  localparam logic [3:0] S_RDW   = 4'd9;
  localparam logic [3:0] S_OFET  = 4'd10;

  // Phases of one distance term.
  localparam logic [1:0] P_FETCH  = 2'd0;
  localparam logic [1:0] P_SQUARE = 2'd1;
  localparam logic [1:0] P_ACCUM  = 2'd2;

  // Effective k and d.
  logic [3:0] k_eff, d_eff;
  assign k_eff = kmc_pkg::clamp_cfg(num_clusters, 4'(MAX_CLUSTERS));
  assign d_eff = kmc_pkg::clamp_cfg(vector_length, 4'(MAX_DIM));

  // Storage.
  logic [31:0]          vstore [MAX_VECTORS*8];
  logic signed [31:0]   cent_mem [64];
  logic signed [SW-1:0] sums_mem [64];
  logic [VW-1:0]        sizes_r [8];

  logic [3:0]    state_r;
  logic [VW-1:0] vcnt_r;
  logic [2:0]    ccnt_r;
  logic [VW-1:0] vi_r;       // vector index in sweeps
  logic [2:0]    ci_r, ji_r; // cluster and component indices
  logic [9:0]    rounds_r;
  logic          changed_r;
  logic          few_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0]   wr_data, rd_q_r;
  logic signed [31:0] vbuf_r [8];  // current vector
  logic [63:0]   acc_r, best_r;
  logic [2:0]    best_c_r;
  logic [63:0]   sq_r;
  logic          sq_v_r;
  logic [1:0]    dph_r;
  logic [2:0]    sq_j_r;
  // Centroid and sum memories.
  logic signed [31:0]   cent_q_r;
  logic signed [SW-1:0] sums_q_r;
  logic [5:0]           cent_addr, sums_addr;
  logic                 cent_we, sums_we;
  logic signed [31:0]   cent_wd;
  logic signed [SW-1:0] sums_base, sums_wd;
  // Divider state.
  logic [SW-1:0] dq_r, drem_r;
  logic [VW-1:0] dden_r;
  logic [6:0]    dstep_r;
  logic          dneg_r;

  logic        is_last_comp;
  logic        done_vec;
  logic [2:0]  pos;
  logic [32:0] diff;
  logic [32:0] mag;
  logic [64:0] acc_sum;
  logic [SW:0] rem_try;
  logic signed [31:0] mean;

  assign item_ready = (state_r == S_LOAD);

  // Load position for the arriving component.
  always_comb begin
    done_vec = 1'b0;
    pos      = ccnt_r;
    if ({1'b0, ccnt_r} >= d_eff - 4'd1) begin
      pos      = 3'(d_eff - 4'd1);
      done_vec = 1'b1;
    end
    is_last_comp = done_vec || item.last;
  end

  // Store write port selection.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {vcnt_r[VIW-1:0], pos};
    wr_data = item.comp;
    if (state_r == S_LOAD && item_valid && vcnt_r < VW'(MAX_VECTORS)) begin
      wr_en = 1'b1;
    end else if (state_r == S_PAD) begin
      wr_en   = 1'b1;
      wr_addr = {vcnt_r[VIW-1:0], ccnt_r};
      wr_data = 32'd0;
    end
  end

  // Read address: during sweeps, vector vi_r component ji_r.
  assign rd_addr = {vi_r[VIW-1:0], ji_r};

  always_ff @(posedge clk) begin
    if (wr_en) vstore[wr_addr] <= wr_data;
    rd_q_r <= vstore[rd_addr];
  end

  // Squared distance term, vector buffer against the fetched centroid component.
  assign diff    = {vbuf_r[ji_r][31], vbuf_r[ji_r]} - {cent_q_r[31], cent_q_r};
  assign mag     = diff[32] ? (~diff + 33'd1) : diff;
  assign acc_sum = {1'b0, acc_r} + {1'b0, sq_r};
  assign rem_try = {drem_r, dq_r[SW-1]} - {{(SW+1-VW){1'b0}}, dden_r};
  assign mean    = dneg_r ? -$signed(dq_r[31:0]) : $signed(dq_r[31:0]);

  // Centroid memory port: seeding and mean updates write, reads are registered.
  assign cent_addr = {ci_r, ji_r};
  always_comb begin
    cent_we = 1'b0;
    cent_wd = mean;
    if (state_r == S_SEED && !(vcnt_r <= VW'(k_eff)) && sq_v_r) begin
      cent_we = 1'b1;
      cent_wd = $signed(rd_q_r);
    end else if (state_r == S_DIVR && dstep_r == 7'(SW)) begin
      cent_we = 1'b1;
    end
  end

  // Sum memory port. A cluster with no member yet this round reads its sums as
  // zero, so the sums need no clearing pass between rounds.
  assign sums_addr = (state_r == S_ACC) ? {best_c_r, ji_r} : {ci_r, ji_r};
  assign sums_base = (sizes_r[best_c_r] == '0) ? '0 : sums_q_r;
  assign sums_wd   = sums_base + SW'($signed(vbuf_r[ji_r]));
  assign sums_we   = (state_r == S_ACC) && sq_v_r;

  always_ff @(posedge clk) begin
    if (cent_we) cent_mem[cent_addr] <= cent_wd;
    cent_q_r <= cent_mem[cent_addr];
    if (sums_we) sums_mem[sums_addr] <= sums_wd;
    sums_q_r <= sums_mem[sums_addr];
  end

  // Output fields.
  assign res_valid   = (state_r == S_OUT);
  assign res_comp    = few_r ? 32'd0 : cent_q_r;
  assign res_cluster = ci_r;
  assign res_index   = ji_r;
  assign res_last    = ({1'b0, ci_r} == k_eff - 4'd1) && ({1'b0, ji_r} == d_eff - 4'd1);
  assign res_few     = few_r;
  assign res_rounds  = rounds_r;

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      vcnt_r    <= '0;
      ccnt_r    <= '0;
      changed_r <= 1'b1;
      vi_r      <= '0;
      ci_r      <= '0;
      ji_r      <= '0;
      rounds_r  <= '0;
      few_r     <= 1'b0;
      sq_v_r    <= 1'b0;
      dph_r     <= P_FETCH;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (item_valid) begin
            if (vcnt_r < VW'(MAX_VECTORS)) begin
              if (item.last && !done_vec) begin
                ccnt_r <= pos + 3'd1;
                state_r <= S_PAD;
              end else if (done_vec) begin
                vcnt_r <= vcnt_r + VW'(1);
                ccnt_r <= '0;
              end else begin
                ccnt_r <= pos + 3'd1;
              end
            end
            if (item.last && !(vcnt_r < VW'(MAX_VECTORS) && !done_vec)) begin
              state_r <= S_SEED;
              vi_r <= '0;
              ci_r <= '0;
              ji_r <= '0;
              rounds_r <= '0;
            end
          end
        end
        S_PAD: begin
          // Zero-fill the rest of a short final vector.
          if ({1'b0, ccnt_r} >= d_eff - 4'd1) begin
            vcnt_r  <= vcnt_r + VW'(1);
            ccnt_r  <= '0;
            state_r <= S_SEED;
            vi_r <= '0;
            ci_r <= '0;
            ji_r <= '0;
            rounds_r <= '0;
          end else begin
            ccnt_r <= ccnt_r + 3'd1;
          end
        end
        S_SEED: begin
          // Copy vector c into centroid c, one component at a time after its store read.
          few_r <= (vcnt_r <= VW'(k_eff));
          if (vcnt_r <= VW'(k_eff)) begin
            ci_r <= '0;
            ji_r <= '0;
            state_r <= S_OFET;
          end else if (sq_v_r) begin
            sq_v_r <= 1'b0;
            if ({1'b0, ji_r} == d_eff - 4'd1) begin
              ji_r <= '0;
              if ({1'b0, ci_r} == k_eff - 4'd1) begin
                ci_r <= '0;
                changed_r <= 1'b1;
                state_r <= S_CLR;
              end else begin
                ci_r <= ci_r + 3'd1;
                vi_r <= vi_r + VW'(1);
              end
            end else begin
              ji_r <= ji_r + 3'd1;
            end
          end else begin
            sq_v_r <= 1'b1;
          end
        end
        S_CLR: begin
          // Start of a round: check stop condition and clear the cluster sizes.
          if (rounds_r >= max_iterations || !changed_r) begin
            ci_r <= '0;
            ji_r <= '0;
            state_r <= S_OFET;
          end else begin
            for (int c = 0; c < 8; c++) sizes_r[c] <= '0;
            vi_r <= '0;
            ji_r <= '0;
            sq_v_r <= 1'b0;
            state_r <= S_RDW;
          end
        end
        S_RDW: begin
          // Fetch vector vi_r into the buffer.
          if (sq_v_r) begin
            vbuf_r[ji_r] <= rd_q_r;
            sq_v_r <= 1'b0;
            if ({1'b0, ji_r} == d_eff - 4'd1) begin
              ji_r <= '0;
              ci_r <= '0;
              acc_r <= '0;
              dph_r <= P_FETCH;
              state_r <= S_DIST;
            end else begin
              ji_r <= ji_r + 3'd1;
            end
          end else begin
            sq_v_r <= 1'b1;
          end
        end
        S_DIST: begin
          // Fetch the centroid component, square the difference, then accumulate.
          unique case (dph_r)
            P_FETCH: begin
              dph_r <= P_SQUARE;
            end
            P_SQUARE: begin
              sq_r   <= mag[31:0] * mag[31:0] + (mag[32] ? 64'hFFFF_FFFE_0000_0001 : 64'd0);
              sq_j_r <= ji_r;
              dph_r  <= P_ACCUM;
            end
            default: begin
              dph_r <= P_FETCH;
              if ({1'b0, sq_j_r} == d_eff - 4'd1) begin
                ji_r <= '0;
                if (ci_r == 3'd0 ||
                    (acc_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc_sum[63:0]) < best_r) begin
                  best_r   <= acc_sum[64] ? '1 : acc_sum[63:0];
                  best_c_r <= ci_r;
                end
                acc_r <= '0;
                if ({1'b0, ci_r} == k_eff - 4'd1) begin
                  state_r <= S_ACC;
                end else begin
                  ci_r <= ci_r + 3'd1;
                end
              end else begin
                acc_r <= acc_sum[64] ? '1 : acc_sum[63:0];
                ji_r <= ji_r + 3'd1;
              end
            end
          endcase
        end
        S_ACC: begin
          // Add the vector into its cluster, one component at a time after its sum read.
          if (!sq_v_r) begin
            sq_v_r <= 1'b1;
          end else begin
            sq_v_r <= 1'b0;
            if ({1'b0, ji_r} == d_eff - 4'd1) begin
              ji_r <= '0;
              sizes_r[best_c_r] <= sizes_r[best_c_r] + VW'(1);
              if (vi_r + VW'(1) == vcnt_r) begin
                ci_r <= '0;
                changed_r <= 1'b0;
                dstep_r <= '0;
                state_r <= S_DIV;
              end else begin
                vi_r <= vi_r + VW'(1);
                state_r <= S_RDW;
              end
            end else begin
              ji_r <= ji_r + 3'd1;
            end
          end
        end
        S_DIV: begin
          // Load the divider for centroid ci_r component ji_r once its sum is read; empty clusters are skipped.
          if (sizes_r[ci_r] == '0) begin
            if ({1'b0, ci_r} == k_eff - 4'd1) begin
              rounds_r <= rounds_r + 10'd1;
              state_r <= S_CLR;
            end else begin
              ci_r <= ci_r + 3'd1;
            end
          end else if (!sq_v_r) begin
            sq_v_r <= 1'b1;
          end else begin
            sq_v_r  <= 1'b0;
            dneg_r  <= sums_q_r[SW-1];
            dq_r    <= sums_q_r[SW-1] ? -sums_q_r : sums_q_r;
            drem_r  <= '0;
            dden_r  <= sizes_r[ci_r];
            dstep_r <= '0;
            state_r <= S_DIVR;
          end
        end
        S_DIVR: begin
          // Restoring division, one quotient bit per cycle.
          if (dstep_r == 7'(SW)) begin
            if (mean != cent_q_r) changed_r <= 1'b1;
            if ({1'b0, ji_r} == d_eff - 4'd1) begin
              ji_r <= '0;
              if ({1'b0, ci_r} == k_eff - 4'd1) begin
                rounds_r <= rounds_r + 10'd1;
                state_r <= S_CLR;
              end else begin
                ci_r <= ci_r + 3'd1;
                state_r <= S_DIV;
              end
            end else begin
              ji_r <= ji_r + 3'd1;
              state_r <= S_DIV;
            end
          end else begin
            dstep_r <= dstep_r + 7'd1;
            if (!rem_try[SW]) begin
              drem_r <= rem_try[SW-1:0];
              dq_r   <= {dq_r[SW-2:0], 1'b1};
            end else begin
              drem_r <= {drem_r[SW-2:0], dq_r[SW-1]};
              dq_r   <= {dq_r[SW-2:0], 1'b0};
            end
          end
        end
        S_OFET: begin
          // Wait for the centroid component to be read.
          state_r <= S_OUT;
        end
        S_OUT: begin
          // Emit k*d results, cluster-major.
          if (res_ready) begin
            if (res_last) begin
              vcnt_r <= '0;
              ccnt_r <= '0;
              changed_r <= 1'b1;
              state_r <= S_LOAD;
            end else if ({1'b0, ji_r} == d_eff - 4'd1) begin
              ji_r <= '0;
              ci_r <= ci_r + 3'd1;
              state_r <= S_OFET;
            end else begin
              ji_r <= ji_r + 3'd1;
              state_r <= S_OFET;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

endmodule
